// ===== hdl/owm_pkg.sv =====
// Shared types and constants for the one-wire bus master.
package owm_pkg;

  // Command codes carried in the action field
  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_RESET = 3'd1;
  localparam logic [2:0] ACT_WRITE = 3'd2;
  localparam logic [2:0] ACT_READ  = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;

  // Bus timing in microseconds
  localparam logic [9:0] US_RST_HIGH = 10'd1000;
  localparam logic [9:0] US_RST_LOW  = 10'd480;
  localparam logic [9:0] US_RST_WAIT = 10'd40;
  localparam logic [9:0] US_SLOT_ONE = 10'd3;
  localparam logic [9:0] US_SLOT_ZERO = 10'd60;
  localparam logic [9:0] US_REC_ZERO = 10'd10;
  localparam logic [9:0] US_RD_WAIT  = 10'd12;
  localparam logic [9:0] US_RD_REC   = 10'd55;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [7:0] CRC_POLY      = 8'h8C;

  // Configuration port
  localparam int unsigned APB_AW = 3;
  localparam logic        REG_TICKS_PER_US = 1'b0;
  localparam logic [9:0]  TPU_RESET = 10'd204;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_HIGH = 4'd1,
    PH_RST_LOW  = 4'd2,
    PH_RST_WAIT = 4'd3,
    PH_WR_LOW   = 4'd4,
    PH_WR_HIGH  = 4'd5,
    PH_RD_LOW   = 4'd6,
    PH_RD_WAIT  = 4'd7,
    PH_RD_REC   = 4'd8
  } phase_e;

  typedef struct packed {
    logic       line_drive_low;
    logic       busy_res;
    logic       presence_found;
    logic [7:0] rx_byte;
    logic [7:0] crc_value;
    logic       crc_ok;
    logic       done_res;
    logic       rejected;
  } res_t;

endpackage

// ===== hdl/owm_if.sv =====
// Command and result channel interfaces for the one-wire bus master.
interface owm_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] tx_byte;
  logic       line_level;

  modport source (output valid, action, tx_byte, line_level, input ready);
  modport sink   (input valid, action, tx_byte, line_level, output ready);
endinterface

interface owm_res_if;
  logic       valid;
  logic       ready;
  logic       line_drive_low;
  logic       busy_res;
  logic       presence_found;
  logic [7:0] rx_byte;
  logic [7:0] crc_value;
  logic       crc_ok;
  logic       done_res;
  logic       rejected;

  modport source (output valid, line_drive_low, busy_res, presence_found, rx_byte,
                  crc_value, crc_ok, done_res, rejected, input ready);
  modport sink   (input valid, line_drive_low, busy_res, presence_found, rx_byte,
                  crc_value, crc_ok, done_res, rejected, output ready);
endinterface

// ===== hdl/owm_cfg.sv =====
// APB-style register for the microsecond prescaler setting.
module owm_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [owm_pkg::APB_AW-1:0]  paddr_i,
  input  logic [31:0]                 pwdata_i,
  output logic [31:0]                 prdata_o,
  output logic                        pready_o,
  output logic [9:0]                  tpu_o
);
  import owm_pkg::*;

  logic [9:0] tpu_q;
  logic       wr_en;

  assign pready_o = 1'b1;
  // paddr_i[1:0] select bytes within the word and play no part in decoding
  assign wr_en = psel_i && penable_i && pwrite_i && (paddr_i[2] == REG_TICKS_PER_US);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q <= TPU_RESET;
    end else if (wr_en) begin
      tpu_q <= pwdata_i[9:0];
    end
  end

  assign prdata_o = (paddr_i[2] == REG_TICKS_PER_US) ? {22'd0, tpu_q} : 32'd0;
  assign tpu_o    = tpu_q;
endmodule

// ===== hdl/owm_seq.sv =====
// Bus sequencer: prescaler, phase state, shift register and CRC-8.
module owm_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [2:0]    action_i,
  input  logic [7:0]    tx_byte_i,
  input  logic          line_level_i,
  input  logic [9:0]    tpu_i,
  output owm_pkg::res_t res_o
);
  import owm_pkg::*;

  phase_e     phase_q, phase_d;
  logic [9:0] us_q, us_d;
  logic [9:0] pc_q, pc_d;
  logic [7:0] shift_q, shift_d;
  logic [3:0] bits_q, bits_d;
  logic [7:0] crc_q, crc_d;
  logic       pres_q, pres_d;
  logic       drv_q, drv_d;
  logic [7:0] rx_q, rx_d;
  logic       done, rej;

  logic [9:0] tpu_eff, pc_inc, us_dec;
  logic [3:0] bits_dec;
  logic [7:0] shift_wr, shift_rd, crc_nx;

  assign tpu_eff  = (tpu_i == 10'd0) ? 10'd1 : tpu_i;
  assign pc_inc   = pc_q + 10'd1;
  assign us_dec   = (us_q != 10'd0) ? us_q - 10'd1 : 10'd0;
  assign bits_dec = bits_q - 4'd1;
  assign shift_wr = {1'b0, shift_q[7:1]};
  assign shift_rd = {line_level_i, shift_q[7:1]};
  assign crc_nx   = {1'b0, crc_q[7:1]} ^ ((crc_q[0] ^ line_level_i) ? CRC_POLY : 8'h00);

  always_comb begin
    phase_d = phase_q;
    us_d    = us_q;
    pc_d    = pc_q;
    shift_d = shift_q;
    bits_d  = bits_q;
    crc_d   = crc_q;
    pres_d  = pres_q;
    drv_d   = drv_q;
    rx_d    = rx_q;
    done    = 1'b0;
    rej     = 1'b0;
    case (action_i)
      ACT_TICK: begin
        if (phase_q != PH_IDLE) begin
          if (pc_inc < tpu_eff) begin
            pc_d = pc_inc;
          end else begin
            pc_d = 10'd0;
            us_d = us_dec;
            if (us_dec == 10'd0) begin
              case (phase_q)
                PH_RST_HIGH: begin
                  phase_d = PH_RST_LOW;  us_d = US_RST_LOW;  drv_d = 1'b1;
                end
                PH_RST_LOW: begin
                  phase_d = PH_RST_WAIT; us_d = US_RST_WAIT; drv_d = 1'b0;
                end
                PH_RST_WAIT: begin
                  pres_d  = ~line_level_i;
                  phase_d = PH_IDLE; us_d = 10'd0; drv_d = 1'b0;
                  done    = 1'b1;
                end
                PH_WR_LOW: begin
                  phase_d = PH_WR_HIGH;
                  us_d    = shift_q[0] ? US_SLOT_ZERO : US_REC_ZERO;
                  drv_d   = 1'b0;
                end
                PH_WR_HIGH: begin
                  shift_d = shift_wr;
                  bits_d  = bits_dec;
                  if (bits_dec == 4'd0) begin
                    phase_d = PH_IDLE; us_d = 10'd0; drv_d = 1'b0;
                    done    = 1'b1;
                  end else begin
                    phase_d = PH_WR_LOW;
                    us_d    = shift_wr[0] ? US_SLOT_ONE : US_SLOT_ZERO;
                    drv_d   = 1'b1;
                  end
                end
                PH_RD_LOW: begin
                  phase_d = PH_RD_WAIT; us_d = US_RD_WAIT; drv_d = 1'b0;
                end
                PH_RD_WAIT: begin
                  shift_d = shift_rd;
                  crc_d   = crc_nx;
                  phase_d = PH_RD_REC; us_d = US_RD_REC; drv_d = 1'b0;
                end
                PH_RD_REC: begin
                  bits_d = bits_dec;
                  if (bits_dec == 4'd0) begin
                    rx_d    = shift_q;
                    phase_d = PH_IDLE; us_d = 10'd0; drv_d = 1'b0;
                    done    = 1'b1;
                  end else begin
                    phase_d = PH_RD_LOW; us_d = US_SLOT_ONE; drv_d = 1'b1;
                  end
                end
                default: begin
                  phase_d = PH_IDLE; us_d = 10'd0; drv_d = 1'b0;
                end
              endcase
            end
          end
        end
      end
      ACT_RESET, ACT_WRITE, ACT_READ, ACT_CLEAR: begin
        if (phase_q != PH_IDLE) begin
          rej = 1'b1;
        end else begin
          case (action_i)
            ACT_RESET: begin
              phase_d = PH_RST_HIGH; us_d = US_RST_HIGH; pc_d = 10'd0; drv_d = 1'b0;
            end
            ACT_WRITE: begin
              shift_d = tx_byte_i;
              bits_d  = BITS_PER_BYTE;
              phase_d = PH_WR_LOW;
              us_d    = tx_byte_i[0] ? US_SLOT_ONE : US_SLOT_ZERO;
              pc_d    = 10'd0;
              drv_d   = 1'b1;
            end
            ACT_READ: begin
              shift_d = 8'd0;
              bits_d  = BITS_PER_BYTE;
              phase_d = PH_RD_LOW; us_d = US_SLOT_ONE; pc_d = 10'd0; drv_d = 1'b1;
            end
            default: begin
              crc_d = 8'd0;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      us_q    <= 10'd0;
      pc_q    <= 10'd0;
      shift_q <= 8'd0;
      bits_q  <= 4'd0;
      crc_q   <= 8'd0;
      pres_q  <= 1'b0;
      drv_q   <= 1'b0;
      rx_q    <= 8'd0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      us_q    <= us_d;
      pc_q    <= pc_d;
      shift_q <= shift_d;
      bits_q  <= bits_d;
      crc_q   <= crc_d;
      pres_q  <= pres_d;
      drv_q   <= drv_d;
      rx_q    <= rx_d;
    end
  end

  always_comb begin
    res_o.line_drive_low = drv_d;
    res_o.busy_res       = (phase_d != PH_IDLE);
    res_o.presence_found = pres_d;
    res_o.rx_byte        = rx_d;
    res_o.crc_value      = crc_d;
    res_o.crc_ok         = (crc_d == 8'd0);
    res_o.done_res       = done;
    res_o.rejected       = rej;
  end

`ifndef NO_ASSERTIONS
  a_idle_prescale_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> pc_q == 10'd0) else $error("prescaler running while idle");
  a_bits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q <= BITS_PER_BYTE) else $error("bit counter out of range");
  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && done |=> phase_q == PH_IDLE) else $error("sequence end left phase busy");
  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && rej |=> $stable(phase_q) && $stable(us_q))
    else $error("rejected command changed timing");
`endif
endmodule

// ===== hdl/owm_obuf.sv =====
// Two-entry result buffer that decouples input ready from result backpressure.
module owm_obuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  owm_pkg::res_t data_i,
  output logic          ready_o,
  output logic          valid_o,
  output owm_pkg::res_t data_o,
  input  logic          ready_i
);
  import owm_pkg::*;

  res_t main_q, skid_q;
  logic main_vld_q, skid_vld_q;
  logic pop;

  assign pop     = main_vld_q && ready_i;
  assign ready_o = !skid_vld_q;
  assign valid_o = main_vld_q;
  assign data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!main_vld_q || pop) begin
      if (skid_vld_q) begin
        main_vld_q <= 1'b1;
        skid_vld_q <= push_i;
      end else begin
        main_vld_q <= push_i;
      end
    end else if (push_i) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_vld_q || pop) begin
      if (skid_vld_q) begin
        main_q <= skid_q;
        if (push_i) begin
          skid_q <= data_i;
        end
      end else if (push_i) begin
        main_q <= data_i;
      end
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end
endmodule

// ===== hdl/one_wire_bus_master.sv =====
// Results: a transaction's result is registered in the result buffer on acceptance.
// Throughput: one transaction per cycle while the result buffer has a free slot.
// Ready drops only when the two-entry result buffer is full.
// Reset: asynchronous, active low; phase idle, counters, CRC and bytes cleared.
// Reset also loads ticks_per_us with 204 and releases the bus line.
module one_wire_bus_master (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  owm_cmd_if.sink                    cmd_i,
  owm_res_if.source                  res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [owm_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import owm_pkg::*;

  logic [9:0] tpu;
  logic       cmd_accept;
  logic       buf_ready;
  res_t       seq_res;
  res_t       out_res;

  // Register file: holds the microsecond prescale setting
  owm_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .tpu_o     (tpu)
  );

  // Accept whenever the result buffer has a free slot
  assign cmd_i.ready = buf_ready;
  assign cmd_accept  = cmd_i.valid && buf_ready;

  // Sequencer: advance bus timing or start a command on each accepted transaction
  owm_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (cmd_accept),
    .action_i     (cmd_i.action),
    .tx_byte_i    (cmd_i.tx_byte),
    .line_level_i (cmd_i.line_level),
    .tpu_i        (tpu),
    .res_o        (seq_res)
  );

  // Result register plus skid entry: hold results while the sink stalls
  owm_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_accept),
    .data_i  (seq_res),
    .ready_o (buf_ready),
    .valid_o (res_o.valid),
    .data_o  (out_res),
    .ready_i (res_o.ready)
  );

  assign res_o.line_drive_low = out_res.line_drive_low;
  assign res_o.busy_res       = out_res.busy_res;
  assign res_o.presence_found = out_res.presence_found;
  assign res_o.rx_byte        = out_res.rx_byte;
  assign res_o.crc_value      = out_res.crc_value;
  assign res_o.crc_ok         = out_res.crc_ok;
  assign res_o.done_res       = out_res.done_res;
  assign res_o.rejected       = out_res.rejected;
endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the one-wire bus master: drives ticks and commands, checks results.
module testbench;
  import owm_pkg::*;

  // Actions above the clear command are spare codes that the block ignores
  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

  localparam int unsigned ITEM_TARGET = 1550;  // input transactions to offer in all
  localparam int unsigned NOISE_ODDS  = 150;   // one stray command per this many ticks
  localparam int unsigned HOLD_CYCLES = 64;    // long receiver hold-off
  localparam int unsigned DRAIN_LIMIT = 1000;
  localparam int unsigned SHOW_LIMIT  = 100;   // mismatch lines shown in full

  localparam logic [APB_AW-1:0] ADDR_TPU = {REG_TICKS_PER_US, 2'b00};

  // ---------------------------------------------------------------------------
  // Bus master tracker: mirrors the sequencer, CRC and held bytes, and keeps
  // the status transactions that are still owed by the block.
  // ---------------------------------------------------------------------------
  class onewire_tracker;
    logic [9:0] tpu;
    phase_e     phase;
    logic [9:0] us_left;
    logic [9:0] prescale;
    logic [7:0] shifter;
    logic [3:0] bits_left;
    logic [7:0] crc;
    logic       presence;
    logic       drive_low;
    logic [7:0] rx_hold;
    res_t       pending_status[$];
    int unsigned errors, checked, finished, refused, presence_hits, crc_good;

    function new();
      tpu       = TPU_RESET;
      phase     = PH_IDLE;
      us_left   = '0;
      prescale  = '0;
      shifter   = '0;
      bits_left = '0;
      crc       = '0;
      presence  = 1'b0;
      drive_low = 1'b0;
      rx_hold   = '0;
    endfunction

    function void enter(phase_e ph, logic [9:0] us, logic low);
      phase     = ph;
      us_left   = us;
      prescale  = '0;
      drive_low = low;
    endfunction

    // Note one accepted command transaction and queue the status it must produce
    function void take_command(logic [2:0] act, logic [7:0] txb, logic line);
      res_t st;
      logic done, rej, fb;
      done = 1'b0;
      rej  = 1'b0;
      if (act == ACT_TICK) begin
        if (phase != PH_IDLE) begin
          prescale = prescale + 10'd1;
          if (prescale >= ((tpu == 10'd0) ? 10'd1 : tpu)) begin
            prescale = '0;
            if (us_left != 10'd0) us_left = us_left - 10'd1;
            if (us_left == 10'd0) begin
              case (phase)
                PH_RST_HIGH: enter(PH_RST_LOW, US_RST_LOW, 1'b1);
                PH_RST_LOW:  enter(PH_RST_WAIT, US_RST_WAIT, 1'b0);
                PH_RST_WAIT: begin
                  presence = ~line;
                  if (~line) presence_hits++;
                  enter(PH_IDLE, '0, 1'b0);
                  done = 1'b1;
                end
                // a one bit recovers for the long slot time, a zero for the short one
                PH_WR_LOW: enter(PH_WR_HIGH, shifter[0] ? US_SLOT_ZERO : US_REC_ZERO, 1'b0);
                PH_WR_HIGH: begin
                  shifter   = shifter >> 1;
                  bits_left = bits_left - 4'd1;
                  if (bits_left == 4'd0) begin
                    enter(PH_IDLE, '0, 1'b0);
                    done = 1'b1;
                  end else begin
                    enter(PH_WR_LOW, shifter[0] ? US_SLOT_ONE : US_SLOT_ZERO, 1'b1);
                  end
                end
                PH_RD_LOW: enter(PH_RD_WAIT, US_RD_WAIT, 1'b0);
                PH_RD_WAIT: begin
                  shifter = {line, shifter[7:1]};
                  fb  = crc[0] ^ line;
                  crc = crc >> 1;
                  if (fb) crc = crc ^ CRC_POLY;
                  enter(PH_RD_REC, US_RD_REC, 1'b0);
                end
                PH_RD_REC: begin
                  bits_left = bits_left - 4'd1;
                  if (bits_left == 4'd0) begin
                    rx_hold = shifter;
                    if (crc == 8'd0) crc_good++;
                    enter(PH_IDLE, '0, 1'b0);
                    done = 1'b1;
                  end else begin
                    enter(PH_RD_LOW, US_SLOT_ONE, 1'b1);
                  end
                end
                default: enter(PH_IDLE, '0, 1'b0);
              endcase
            end
          end
        end
      end else if (act <= ACT_CLEAR) begin
        if (phase != PH_IDLE) begin
          rej = 1'b1;
          refused++;
        end else begin
          case (act)
            ACT_RESET: enter(PH_RST_HIGH, US_RST_HIGH, 1'b0);
            ACT_WRITE: begin
              shifter   = txb;
              bits_left = BITS_PER_BYTE;
              enter(PH_WR_LOW, txb[0] ? US_SLOT_ONE : US_SLOT_ZERO, 1'b1);
            end
            ACT_READ: begin
              shifter   = '0;
              bits_left = BITS_PER_BYTE;
              enter(PH_RD_LOW, US_SLOT_ONE, 1'b1);
            end
            default: crc = '0;
          endcase
        end
      end
      if (done) finished++;
      st.line_drive_low = drive_low;
      st.busy_res       = (phase != PH_IDLE);
      st.presence_found = presence;
      st.rx_byte        = rx_hold;
      st.crc_value      = crc;
      st.crc_ok         = (crc == 8'd0);
      st.done_res       = done;
      st.rejected       = rej;
      pending_status.push_back(st);
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= SHOW_LIMIT)
          $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        else if (errors == SHOW_LIMIT + 1)
          $display("%0t: further mismatches not shown", $time);
      end
    endfunction

    // Compare one accepted status transaction with the oldest one owed
    function void check_result(res_t got);
      res_t want;
      if (pending_status.size() == 0) begin
        errors++;
        $display("%0t: status transaction arrived with none expected", $time);
        return;
      end
      want = pending_status.pop_front();
      checked++;
      compare("line_drive_low", want.line_drive_low, got.line_drive_low);
      compare("busy_res",       want.busy_res,       got.busy_res);
      compare("presence_found", want.presence_found, got.presence_found);
      compare("rx_byte",        want.rx_byte,        got.rx_byte);
      compare("crc_value",      want.crc_value,      got.crc_value);
      compare("crc_ok",         want.crc_ok,         got.crc_ok);
      compare("done_res",       want.done_res,       got.done_res);
      compare("rejected",       want.rejected,       got.rejected);
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and the block
  // ---------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni;

  always #5 clk_i = ~clk_i;

  owm_cmd_if cmd_bus ();
  owm_res_if res_bus ();

  logic              psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [31:0]       pwdata, prdata;

  one_wire_bus_master DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_bus),
    .res_o   (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  onewire_tracker board;

  logic        tx_gaps;        // sender may idle between transactions
  logic        rx_gaps;        // receiver may stall
  logic        hold_req;       // ask the receiver for one long hold-off
  int unsigned noise_odds;     // 0 disables stray commands inside a sequence
  int unsigned commands_sent;
  int unsigned items_sent;

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------

  // Offer one transaction at the falling edge, hold it until accepted, and
  // record it against the tracker at the accepting rising edge.
  task automatic send_item(logic [2:0] act, logic [7:0] txb, logic line);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      @(negedge clk_i);
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk_i);
    end
    @(negedge clk_i);
    cmd_bus.valid      <= 1'b1;
    cmd_bus.action     <= act;
    cmd_bus.tx_byte    <= txb;
    cmd_bus.line_level <= line;
    do @(posedge clk_i); while (!cmd_bus.ready);
    board.take_command(act, txb, line);
    items_sent++;
    if (act != ACT_TICK && act <= ACT_CLEAR) commands_sent++;
  endtask

  // Model the slave on the wire: answer presence during the reset wait and the
  // device byte during read sampling; elsewhere the level is don't-care, so
  // randomise it. A wild sequence randomises everything.
  function automatic logic bus_level(logic [7:0] dev_byte, logic present, logic wild);
    if (wild) return 1'($urandom_range(0, 1));
    case (board.phase)
      PH_RST_WAIT: return ~present;
      PH_RD_WAIT:  return dev_byte[3'(BITS_PER_BYTE - board.bits_left)];
      default:     return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // Tick until the sequence ends or the transaction budget runs out, now and
  // then slipping in a stray command
  task automatic tick_until_idle(logic [7:0] dev_byte, logic present);
    logic wild;
    wild = (noise_odds != 0) && ($urandom_range(0, 9) == 0);
    while (board.phase != PH_IDLE && items_sent < ITEM_TARGET) begin
      if (noise_odds != 0 && $urandom_range(1, noise_odds) == 1)
        send_item(3'($urandom_range(ACT_RESET, ACT_SPARE_LAST)), 8'($urandom),
                  1'($urandom_range(0, 1)));
      else
        send_item(ACT_TICK, 8'($urandom), bus_level(dev_byte, present, wild));
    end
  endtask

  task automatic run_sequence(logic [2:0] act, logic [7:0] data, logic present);
    send_item(act, data, 1'($urandom_range(0, 1)));
    tick_until_idle(data, present);
  endtask

  // Drop valid and wait until every owed status transaction has come back
  task automatic drain();
    int unsigned waited;
    waited = 0;
    @(negedge clk_i);
    cmd_bus.valid <= 1'b0;
    while (board.pending_status.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  task automatic read_tpu();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_TPU;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {22'd0, board.tpu}) begin
      board.errors++;
      $display("%0t: ticks_per_us read mismatch, expected %0h, got %0h",
               $time, board.tpu, prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Only ever called with the bus master idle and the status stream drained
  task automatic write_tpu(logic [9:0] value);
    drain();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_TPU;
    pwdata  <= {22'($urandom), value};  // upper bits are not stored
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.tpu = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    read_tpu();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, plus one long hold-off on request so that the
  // result buffer fills and the block pushes back on the sender.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    stall = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end else if (stall == 0 && rx_gaps && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 5);
      end
      if (stall != 0) begin
        res_bus.ready <= 1'b0;
        stall--;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_bus.valid && res_bus.ready)
      board.check_result({res_bus.line_drive_low, res_bus.busy_res, res_bus.presence_found,
                          res_bus.rx_byte, res_bus.crc_value, res_bus.crc_ok,
                          res_bus.done_res, res_bus.rejected});
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int a;
    logic [7:0] data;

    // Initialise every input before the first edge
    cmd_bus.valid      = 1'b0;
    cmd_bus.action     = ACT_TICK;
    cmd_bus.tx_byte    = '0;
    cmd_bus.line_level = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    tx_gaps            = 1'b1;
    rx_gaps            = 1'b1;
    hold_req           = 1'b0;
    noise_odds         = 0;
    commands_sent      = 0;
    items_sent         = 0;
    board              = new();
    rst_ni             = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Check the reset value, then drop to the fastest timing
    read_tpu();
    write_tpu(10'd1);

    // Idle behaviour: clear, bare tick, spare codes
    run_sequence(ACT_CLEAR, 8'h00, 1'b0);
    send_item(ACT_TICK, 8'hFF, 1'b0);
    for (a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
      send_item(3'(a), 8'hC3, 1'b0);

    // Random byte write; every command offered just after the start is refused,
    // and a long receiver hold-off makes the block push back on the sender
    data     = 8'($urandom);
    hold_req = 1'b1;
    send_item(ACT_WRITE, data, 1'b1);
    for (a = ACT_RESET; a <= ACT_CLEAR; a++)
      send_item(3'(a), 8'h5A, 1'b0);
    noise_odds = NOISE_ODDS;
    tick_until_idle(data, 1'b0);

    // A zero prescale must behave as one tick per microsecond
    write_tpu(10'd0);

    // Random device byte read with stray commands inside it
    run_sequence(ACT_READ, 8'($urandom), 1'b0);

    // Last part, no idling on either side: clear a non-zero CRC, then a reset
    // with a device answering until the transaction budget is spent
    tx_gaps    = 1'b0;
    rx_gaps    = 1'b0;
    noise_odds = 0;
    run_sequence(ACT_CLEAR, 8'h00, 1'b0);
    run_sequence(ACT_RESET, 8'h00, 1'b1);
    drain();

    if (board.pending_status.size() != 0) begin
      board.errors++;
      $display("%0t: %0d status transactions never arrived",
               $time, board.pending_status.size());
    end

    $display("Covered %0d input transactions with %0d commands, %0d results checked.",
             items_sent, commands_sent, board.checked);
    $display("Sequences finished %0d, presence found %0d, commands refused %0d, CRC clean %0d.",
             board.finished, board.presence_hits, board.refused, board.crc_good);
    if (board.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2000000;
    $display("Timeout: run did not complete");
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== one_wire_bus_master.f =====
hdl/owm_pkg.sv
hdl/owm_if.sv
hdl/owm_cfg.sv
hdl/owm_seq.sv
hdl/owm_obuf.sv
hdl/one_wire_bus_master.sv
sim/testbench.sv
